### rtl/ipm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipm_pkg
// Shared constants and widths for the isomorphic pattern match unit.
// ----------------------------------------------------------------------------
package ipm_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_W      = 5;
    localparam int IDX_W         = $clog2(ALPHABET_SIZE);

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // tuser bit positions on the input side
    localparam int TU_WORD_HAS = 0;
    localparam int TU_PATT_HAS = 1;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [IDX_W-1:0]    t_idx;

endpackage

### rtl/isomorphic_pattern_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isomorphic_pattern_match_unit
// Checks a streamed word against a streamed pattern under a one-to-one
// letter mapping; one verdict item per word.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_axis  | in  | tdata: word_letter, pattern_letter; tuser: has flags; tlast
//  m_axis  | out | tdata: matches_res
//
//  One position per cycle sustained; two stages: map read, then check and
//  write back. Map letters sit in two 26-entry RAMs with a registered read;
//  a same-cycle write to the address being read is forwarded.
//  Reset (synchronous, active low) clears all valid bits, the fail flag and
//  the output valid flag. Only the last position of a word stalls, and only
//  while the output register is full and not taken.
module isomorphic_pattern_match_unit
    import ipm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [4:0] word_letter, [9:5] pattern_letter, [15:10] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] word_has_letter, [1] pattern_has_letter
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] matches_res, [7:1] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // map RAMs: letter only, valid bits in flops
    t_letter mem_w2p [ALPHABET_SIZE];
    t_letter mem_p2w [ALPHABET_SIZE];
    t_letter r_w2p_rd, r_p2w_rd;

    logic [ALPHABET_SIZE-1:0] r_w2p_vld, n_w2p_vld;
    logic [ALPHABET_SIZE-1:0] r_p2w_vld, n_p2w_vld;
    logic                     r_failed, n_failed;

    // check stage
    logic    r_s1_vld;
    t_letter r_s1_w, r_s1_p;
    logic    r_s1_wh, r_s1_ph, r_s1_last;
    logic    r_fw_w2p, r_fw_p2w;
    t_letter r_fw_w2p_data, r_fw_p2w_data;

    logic r_out_vld;
    logic r_out_res;

    t_letter in_w, in_p;
    logic    accept, s1_done;
    logic    w_ok, p_ok, both_in;
    t_idx    w_idx, p_idx;
    logic    w_map_v, p_map_v;
    t_letter w2p_val, p2w_val;
    logic    wr_en, fail_now;

    assign in_w = s_axis_tdata[LETTER_W-1:0];
    assign in_p = s_axis_tdata[2*LETTER_W-1:LETTER_W];

    assign s1_done       = r_s1_vld && (!r_s1_last || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_ok    = {1'b0, r_s1_w} < (LETTER_W+1)'(ALPHABET_SIZE);
        p_ok    = {1'b0, r_s1_p} < (LETTER_W+1)'(ALPHABET_SIZE);
        w_idx   = r_s1_w[IDX_W-1:0];
        p_idx   = r_s1_p[IDX_W-1:0];
        w_map_v = w_ok ? r_w2p_vld[w_idx] : 1'b0;
        p_map_v = p_ok ? r_p2w_vld[p_idx] : 1'b0;
        w2p_val = r_fw_w2p ? r_fw_w2p_data : r_w2p_rd;
        p2w_val = r_fw_p2w ? r_fw_p2w_data : r_p2w_rd;
        both_in = r_s1_wh && r_s1_ph;

        wr_en    = 1'b0;
        fail_now = 1'b0;
        if (both_in) begin
            if (!w_ok || !p_ok) begin
                fail_now = 1'b1;
            end else if (!w_map_v && !p_map_v) begin
                wr_en = 1'b1;
            end else if (!(w_map_v && p_map_v && w2p_val == r_s1_p && p2w_val == r_s1_w)) begin
                fail_now = 1'b1;
            end
        end else if (r_s1_wh != r_s1_ph) begin
            fail_now = 1'b1;
        end
        wr_en = wr_en && s1_done;

        n_w2p_vld = r_w2p_vld;
        n_p2w_vld = r_p2w_vld;
        n_failed  = r_failed;
        if (s1_done) begin
            if (wr_en) begin
                n_w2p_vld[w_idx] = 1'b1;
                n_p2w_vld[p_idx] = 1'b1;
            end
            n_failed = r_failed || fail_now;
            if (r_s1_last) begin
                n_w2p_vld = '0;
                n_p2w_vld = '0;
                n_failed  = 1'b0;
            end
        end
    end

    // RAM ports: read on accept, write back from the check stage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_w2p[w_idx] <= r_s1_p;
            mem_p2w[p_idx] <= r_s1_w;
        end
        if (accept) begin
            r_w2p_rd <= mem_w2p[in_w[IDX_W-1:0]];
            r_p2w_rd <= mem_p2w[in_p[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_w2p_vld <= '0;
            r_p2w_vld <= '0;
            r_failed  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_w2p_vld <= n_w2p_vld;
            r_p2w_vld <= n_p2w_vld;
            r_failed  <= n_failed;
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_done && r_s1_last) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_w        <= in_w;
            r_s1_p        <= in_p;
            r_s1_wh       <= s_axis_tuser[TU_WORD_HAS];
            r_s1_ph       <= s_axis_tuser[TU_PATT_HAS];
            r_s1_last     <= s_axis_tlast;
            // a write in this cycle lands after the RAM read: bypass it
            r_fw_w2p      <= wr_en && (w_idx == in_w[IDX_W-1:0]);
            r_fw_p2w      <= wr_en && (p_idx == in_p[IDX_W-1:0]);
            r_fw_w2p_data <= r_s1_p;
            r_fw_p2w_data <= r_s1_w;
        end
        if (s1_done && r_s1_last) begin
            r_out_res <= !(r_failed || fail_now);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, r_out_res};

    // the two maps always hold the same number of valid entries
    a_map_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_w2p_vld) == $countones(r_p2w_vld))
        else $error("map valid counts differ");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && r_s1_last) |=> (r_w2p_vld == '0 && r_p2w_vld == '0 && !r_failed))
        else $error("maps not cleared after last item");

    a_write_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (!r_w2p_vld[w_idx] && !r_p2w_vld[p_idx]))
        else $error("write to a mapped entry");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |-> !(s1_done && r_s1_last))
        else $error("result overwrote a pending item");

endmodule
